// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/gnp_pkg.sv
`timescale 1ns / 1ps

package gnp_pkg;

    localparam int COORD_W        = 10;
    localparam int COORD_LIMIT    = 1 << COORD_W;
    localparam int WIDTH_W        = 11;
    localparam int PIX_W          = 8;
    localparam int MODE_W         = 2;
    localparam int MAX_POINTS_DEF = 1024;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(1024);

    // Store word: visited flag, row, column.
    localparam int MEM_W = 2 * COORD_W + 1;
    localparam int DIST_W = 2 * COORD_W + 1;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REQ   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

endpackage

// File: rtl/core/gnp_if.sv
`timescale 1ns / 1ps

interface gnp_in_if import gnp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [PIX_W-1:0]  pixel_value;

    modport source (output valid, output mode, output pixel_value, input ready);
    modport sink   (input valid, input mode, input pixel_value, output ready);
endinterface

interface gnp_out_if import gnp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic               path_done;
    logic               store_overflow;

    modport source (output valid, output point_x, output point_y, output path_done,
                    output store_overflow, input ready);
    modport sink   (input valid, input point_x, input point_y, input path_done,
                    input store_overflow, output ready);
endinterface

interface gnp_cfg_if import gnp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [WIDTH_W-1:0] image_width;

    modport source (output valid, output image_width, input ready);
    modport sink   (input valid, input image_width, output ready);
endinterface

// File: rtl/core/greedy_nearest_neighbor_path.sv
// Load (mode 0), clear (mode 2) and unused codes: taken back to back while idle.
// Path request (mode 1): result registered once the whole store has been searched, and
//   later while an earlier result is still held; the distance pipeline reads one
//   store entry per cycle over its one read port, and the block takes no item meanwhile.
// Reset (i_rst_n low, synchronous): control state cleared, image_width back to 1024;
//   point store contents stay as they are and need no clearing pass.
`timescale 1ns / 1ps

module greedy_nearest_neighbor_path import gnp_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gnp_cfg_if.sink   i_cfg,
    gnp_in_if.sink    i_pix,
    gnp_out_if.source o_res
);

    localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNTW = $clog2(MAX_POINTS + 1);

    typedef enum logic {ST_IDLE, ST_SEARCH} t_state;

    t_state r_state;

    logic [WIDTH_W-1:0] r_width;
    logic [CNTW-1:0]    r_count;
    logic [COORD_W-1:0] r_col, r_row, r_cur_x, r_cur_y;
    logic               r_overflow;

    // point store
    logic [MEM_W-1:0] mem [MAX_POINTS];
    logic [MEM_W-1:0] r_rd;

    // search pipeline
    logic [CNTW-1:0]    r_issue;
    logic               r_p0_v;
    logic [IW-1:0]      r_p0_idx;
    logic               r_p1_v;
    logic [IW-1:0]      r_p1_idx;
    logic [COORD_W-1:0] r_p1_dx, r_p1_dy, r_p1_x, r_p1_y;
    logic               r_p2_v;
    logic [IW-1:0]      r_p2_idx;
    logic [2*COORD_W-1:0] r_p2_sqx, r_p2_sqy;
    logic [COORD_W-1:0] r_p2_x, r_p2_y;

    logic               r_found;
    logic [DIST_W-1:0]  r_best_d;
    logic [IW-1:0]      r_best_idx;
    logic [COORD_W-1:0] r_best_x, r_best_y;

    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_x, r_out_y;
    logic               r_out_done, r_out_ovf;

    logic               in_acc;
    logic [WIDTH_W-1:0] eff_width;
    logic               col_wrap;
    logic               load_wr;
    logic               issue_go;
    logic               search_end;
    logic               out_free;
    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [MEM_W-1:0]   mem_wdata;
    logic [COORD_W-1:0] rd_x, rd_y;
    logic [DIST_W-1:0]  n_dist;

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = (r_state == ST_IDLE);
    assign in_acc      = i_pix.valid && i_pix.ready;

    assign o_res.valid          = r_out_valid;
    assign o_res.point_x        = r_out_x;
    assign o_res.point_y        = r_out_y;
    assign o_res.path_done      = r_out_done;
    assign o_res.store_overflow = r_out_ovf;

    // width 0 behaves as 1, anything above the coordinate range saturates
    always_comb begin
        if (r_width == '0) begin
            eff_width = WIDTH_W'(1);
        end else if (r_width > WIDTH_W'(COORD_LIMIT)) begin
            eff_width = WIDTH_W'(COORD_LIMIT);
        end else begin
            eff_width = r_width;
        end
    end

    assign col_wrap = (({1'b0, r_col} + WIDTH_W'(1)) >= eff_width);
    assign load_wr  = in_acc && (i_pix.mode == MODE_LOAD) && (i_pix.pixel_value != '0)
                      && (r_count < CNTW'(MAX_POINTS));

    assign out_free   = !r_out_valid || o_res.ready;
    assign issue_go   = (r_state == ST_SEARCH) && (r_issue != r_count);
    assign search_end = (r_state == ST_SEARCH) && (r_issue == r_count)
                        && !r_p0_v && !r_p1_v && !r_p2_v && out_free;

    assign rd_x   = r_rd[COORD_W-1:0];
    assign rd_y   = r_rd[2*COORD_W-1:COORD_W];
    assign n_dist = {1'b0, r_p2_sqx} + {1'b0, r_p2_sqy};

    // one write per cycle: new points while idle, the visited mark at search end
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_count[IW-1:0];
        mem_wdata = {1'b0, r_row, r_col};
        if (load_wr) begin
            mem_we = 1'b1;
        end else if (search_end && r_found) begin
            mem_we    = 1'b1;
            mem_waddr = r_best_idx;
            mem_wdata = {1'b1, r_best_y, r_best_x};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue_go) begin
            r_rd <= mem[r_issue[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_width     <= WIDTH_RESET;
            r_count     <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_overflow  <= 1'b0;
            r_issue     <= '0;
            r_p0_v      <= 1'b0;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_width <= i_cfg.image_width;
            end

            if (o_res.valid && o_res.ready && !search_end) begin
                r_out_valid <= 1'b0;
            end

            // stage 0: registered read, stage 1: abs diffs, stage 2: squares,
            // stage 3: sum and strict compare (earliest index wins ties)
            r_p0_v   <= issue_go;
            r_p0_idx <= r_issue[IW-1:0];

            r_p1_v   <= r_p0_v && !r_rd[MEM_W-1];
            r_p1_idx <= r_p0_idx;
            r_p1_x   <= rd_x;
            r_p1_y   <= rd_y;
            r_p1_dx  <= (r_cur_x > rd_x) ? (r_cur_x - rd_x) : (rd_x - r_cur_x);
            r_p1_dy  <= (r_cur_y > rd_y) ? (r_cur_y - rd_y) : (rd_y - r_cur_y);

            r_p2_v   <= r_p1_v;
            r_p2_idx <= r_p1_idx;
            r_p2_x   <= r_p1_x;
            r_p2_y   <= r_p1_y;
            r_p2_sqx <= {{COORD_W{1'b0}}, r_p1_dx} * {{COORD_W{1'b0}}, r_p1_dx};
            r_p2_sqy <= {{COORD_W{1'b0}}, r_p1_dy} * {{COORD_W{1'b0}}, r_p1_dy};

            if (r_p2_v && (!r_found || (n_dist < r_best_d))) begin
                r_found    <= 1'b1;
                r_best_d   <= n_dist;
                r_best_idx <= r_p2_idx;
                r_best_x   <= r_p2_x;
                r_best_y   <= r_p2_y;
            end

            if (issue_go) begin
                r_issue <= r_issue + CNTW'(1);
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        priority if (i_pix.mode == MODE_LOAD) begin
                            if (load_wr) begin
                                r_count <= r_count + CNTW'(1);
                            end else if (i_pix.pixel_value != '0) begin
                                r_overflow <= 1'b1;
                            end
                            if (col_wrap) begin
                                r_col <= '0;
                                r_row <= r_row + COORD_W'(1);
                            end else begin
                                r_col <= r_col + COORD_W'(1);
                            end
                        end else if (i_pix.mode == MODE_REQ) begin
                            r_issue <= '0;
                            r_found <= 1'b0;
                            r_state <= ST_SEARCH;
                        end else if (i_pix.mode == MODE_CLEAR) begin
                            r_count    <= '0;
                            r_col      <= '0;
                            r_row      <= '0;
                            r_cur_x    <= '0;
                            r_cur_y    <= '0;
                            r_overflow <= 1'b0;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_SEARCH: begin
                    if (search_end) begin
                        r_out_valid <= 1'b1;
                        r_out_ovf   <= r_overflow;
                        r_out_done  <= !r_found;
                        if (r_found) begin
                            r_out_x <= r_best_x;
                            r_out_y <= r_best_y;
                            r_cur_x <= r_best_x;
                            r_cur_y <= r_best_y;
                        end else begin
                            r_out_x <= '0;
                            r_out_y <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/gnp_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gnp_checker import gnp_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic [MODE_W-1:0]  i_in_mode,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [COORD_W-1:0] i_out_x,
    input logic [COORD_W-1:0] i_out_y,
    input logic               i_out_done,
    input logic               i_out_ovf
);

    // a finished path returns no coordinates
    `ASSERT_SAME(a_done_zero, i_clk, i_rst_n, i_out_valid && i_out_done, (i_out_x == '0) && (i_out_y == '0))

    // a path request keeps the block busy while the store is searched
    `ASSERT_NEXT(a_req_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_mode == MODE_REQ), !i_in_ready)

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_x) && $stable(i_out_y) && $stable(i_out_done) && $stable(i_out_ovf))

endmodule

bind greedy_nearest_neighbor_path gnp_checker u_gnp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_in_mode   (i_pix.mode),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_x     (o_res.point_x),
    .i_out_y     (o_res.point_y),
    .i_out_done  (o_res.path_done),
    .i_out_ovf   (o_res.store_overflow)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import gnp_pkg::*;

    localparam int MAX_PTS = MAX_POINTS_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RAND_ITEMS = 550;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               done;
        logic               ovf;
    } t_path_res;

    typedef enum logic { ROW_CFG, ROW_ITEM } t_row_kind;

    // chk set: the result is typed in the row, else it comes from the path model
    typedef struct packed {
        t_row_kind          kind;
        logic [MODE_W-1:0]  mode;
        logic [WIDTH_W-1:0] val;
        logic               chk;
        t_path_res          want;
    } t_dir_row;

    localparam t_path_res NO_RES = '{10'd0, 10'd0, 1'b0, 1'b0};
    localparam t_path_res DONE_RES = '{10'd0, 10'd0, 1'b1, 1'b0};

    localparam int DIR_ROWS = 29;
    localparam t_dir_row DIR_TAB [0:DIR_ROWS-1] = '{
        '{ROW_ITEM, MODE_REQ,    11'd0,    1'b1, DONE_RES},   // empty store after reset
        '{ROW_CFG,  MODE_LOAD,   11'd0,    1'b0, NO_RES},     // width 0 acts as 1
        '{ROW_ITEM, MODE_LOAD,   11'd255,  1'b0, NO_RES},
        '{ROW_ITEM, MODE_LOAD,   11'd1,    1'b0, NO_RES},
        '{ROW_ITEM, MODE_LOAD,   11'd0,    1'b0, NO_RES},
        '{ROW_ITEM, MODE_LOAD,   11'd128,  1'b0, NO_RES},
        '{ROW_ITEM, MODE_REQ,    11'd0,    1'b1, '{10'd0, 10'd0, 1'b0, 1'b0}},
        '{ROW_ITEM, MODE_REQ,    11'd0,    1'b1, '{10'd0, 10'd1, 1'b0, 1'b0}},
        '{ROW_ITEM, MODE_LOAD,   11'h055,  1'b0, NO_RES},     // joins a path in progress
        '{ROW_ITEM, MODE_REQ,    11'd0,    1'b0, NO_RES},
        '{ROW_ITEM, MODE_REQ,    11'd0,    1'b0, NO_RES},
        '{ROW_ITEM, MODE_REQ,    11'd0,    1'b1, DONE_RES},
        '{ROW_ITEM, MODE_UNUSED, 11'h0AA,  1'b0, NO_RES},
        '{ROW_ITEM, MODE_CLEAR,  11'd0,    1'b0, NO_RES},
        '{ROW_CFG,  MODE_LOAD,   11'd2047, 1'b0, NO_RES},     // clamps to 1024
        '{ROW_ITEM, MODE_REQ,    11'd0,    1'b1, DONE_RES},
        '{ROW_CFG,  MODE_LOAD,   11'd3,    1'b0, NO_RES},
        '{ROW_ITEM, MODE_LOAD,   11'd0,    1'b0, NO_RES},
        '{ROW_ITEM, MODE_LOAD,   11'd0,    1'b0, NO_RES},
        '{ROW_ITEM, MODE_LOAD,   11'd255,  1'b0, NO_RES},     // (2,0)
        '{ROW_ITEM, MODE_LOAD,   11'd0,    1'b0, NO_RES},
        '{ROW_ITEM, MODE_LOAD,   11'd0,    1'b0, NO_RES},
        '{ROW_ITEM, MODE_LOAD,   11'd0,    1'b0, NO_RES},
        '{ROW_ITEM, MODE_LOAD,   11'd200,  1'b0, NO_RES},     // (0,2), same distance
        '{ROW_ITEM, MODE_REQ,    11'd0,    1'b1, '{10'd2, 10'd0, 1'b0, 1'b0}},
        '{ROW_ITEM, MODE_REQ,    11'd0,    1'b0, NO_RES},
        '{ROW_CFG,  MODE_LOAD,   11'd1,    1'b0, NO_RES},     // shrink mid-row
        '{ROW_ITEM, MODE_LOAD,   11'd9,    1'b0, NO_RES},
        '{ROW_ITEM, MODE_REQ,    11'd0,    1'b0, NO_RES}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    gnp_in_if  pix_if ();
    gnp_out_if path_if ();
    gnp_cfg_if width_if ();

    greedy_nearest_neighbor_path #(
        .MAX_POINTS(MAX_PTS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (width_if),
        .i_pix  (pix_if),
        .o_res  (path_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // path model state
    int unsigned        width_reg = WIDTH_RESET;
    logic [COORD_W-1:0] pt_x [MAX_PTS];
    logic [COORD_W-1:0] pt_y [MAX_PTS];
    bit                 visited [MAX_PTS];
    int unsigned        n_pts = 0;
    int unsigned        n_visited = 0;
    int unsigned        col = 0;
    int unsigned        row = 0;
    int unsigned        cur_x = 0;
    int unsigned        cur_y = 0;
    bit                 dropped = 1'b0;

    t_path_res path_q [$];
    int        err_count = 0;
    int        n_items = 0;
    int        n_path_pts = 0;
    int        n_done = 0;
    int        n_width_writes = 0;
    int        cycles = 0;
    bit        gaps_on = 1'b1;
    bit        sink_stalls = 1'b1;
    int        stall_left = 0;
    t_path_res got;
    t_path_res want;

    function automatic int unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > COORD_LIMIT) return COORD_LIMIT;
        return width_reg;
    endfunction

    function automatic void clear_frame();
        for (int i = 0; i < MAX_PTS; i++) visited[i] = 1'b0;
        n_pts = 0;
        n_visited = 0;
        col = 0;
        row = 0;
        cur_x = 0;
        cur_y = 0;
        dropped = 1'b0;
    endfunction

    // Advances the path model by one transaction; returns 1 when a result is due.
    function automatic bit step_path(input logic [MODE_W-1:0] m, input logic [PIX_W-1:0] p,
                                     output t_path_res r);
        int unsigned dx, dy, d, best, best_d;
        bit          found;
        r = NO_RES;
        found = 1'b0;
        best = 0;
        best_d = 0;
        if (m == MODE_LOAD) begin
            if (p != 0) begin
                if (n_pts < MAX_PTS) begin
                    pt_x[n_pts] = COORD_W'(col);
                    pt_y[n_pts] = COORD_W'(row);
                    visited[n_pts] = 1'b0;
                    n_pts++;
                end else begin
                    dropped = 1'b1;
                end
            end
            if (col + 1 >= eff_width()) begin
                col = 0;
                row = (row + 1) % COORD_LIMIT;
            end else begin
                col++;
            end
            return 1'b0;
        end
        if (m == MODE_CLEAR) begin
            clear_frame();
            return 1'b0;
        end
        if (m != MODE_REQ) return 1'b0;
        for (int unsigned i = 0; i < n_pts; i++) begin
            if (!visited[i]) begin
                dx = (cur_x > pt_x[i]) ? cur_x - pt_x[i] : pt_x[i] - cur_x;
                dy = (cur_y > pt_y[i]) ? cur_y - pt_y[i] : pt_y[i] - cur_y;
                d = dx * dx + dy * dy;
                if (!found || d < best_d) begin
                    found = 1'b1;
                    best = i;
                    best_d = d;
                end
            end
        end
        if (found) begin
            visited[best] = 1'b1;
            n_visited++;
            cur_x = pt_x[best];
            cur_y = pt_y[best];
            r.x = pt_x[best];
            r.y = pt_y[best];
            n_path_pts++;
        end else begin
            r.done = 1'b1;
            n_done++;
        end
        r.ovf = dropped;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string field, int got_v, int want_v);
        $display("[%0d] mismatch on %s: got %0d, expected %0d", cycles, field, got_v, want_v);
        err_count++;
    endtask

    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return '0;
        if (r < 52) return 8'd255;
        if (r < 56) return 8'd1;
        return PIX_W'($urandom_range(2, 254));
    endfunction

    function automatic logic [WIDTH_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 11'd2047;
            2: return 11'd1024;
            3: return 11'd1;
            4: return WIDTH_W'($urandom_range(1025, 2047));
            default: return WIDTH_W'($urandom_range(2, 12));
        endcase
    endfunction

    task automatic send_item(input logic [MODE_W-1:0] m, input logic [PIX_W-1:0] p,
                             input bit typed, input t_path_res typed_res);
        int        gap;
        t_path_res r;
        gap = pick_gap();
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.mode <= m;
        pix_if.pixel_value <= p;
        do @(posedge i_clk); while (!(pix_if.valid && pix_if.ready));
        if (m != MODE_UNUSED) n_items++;
        if (step_path(m, p, r)) path_q = {path_q, (typed ? typed_res : r)};
    endtask

    // Hold off input until every pending result is back, then let loads drain.
    task automatic settle();
        pix_if.valid <= 1'b0;
        while (path_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [WIDTH_W-1:0] w);
        width_if.valid <= 1'b1;
        width_if.image_width <= w;
        do @(posedge i_clk); while (!(width_if.valid && width_if.ready));
        width_if.valid <= 1'b0;
        width_reg = w;
        n_width_writes++;
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            path_if.ready <= 1'b0;
        end else if (sink_stalls && $urandom_range(0, 99) < 20) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
            path_if.ready <= 1'b0;
        end else begin
            path_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && path_if.valid && path_if.ready) begin
            got = '{path_if.point_x, path_if.point_y, path_if.path_done,
                    path_if.store_overflow};
            if (path_q.size() == 0) begin
                report_mismatch("result with no request pending", got.x, 0);
            end else begin
                want = path_q.pop_front();
                if (got.x !== want.x) report_mismatch("point_x", got.x, want.x);
                if (got.y !== want.y) report_mismatch("point_y", got.y, want.y);
                if (got.done !== want.done) report_mismatch("path_done", got.done, want.done);
                if (got.ovf !== want.ovf) report_mismatch("store_overflow", got.ovf, want.ovf);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", path_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int stop_at;
        int nload;
        int nreq;
        int r;
        pix_if.valid = 1'b0;
        pix_if.mode = MODE_LOAD;
        pix_if.pixel_value = '0;
        width_if.valid = 1'b0;
        width_if.image_width = '0;
        path_if.ready = 1'b0;
        clear_frame();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIR_TAB[i].kind == ROW_CFG) begin
                settle();
                write_width(DIR_TAB[i].val);
            end else begin
                send_item(DIR_TAB[i].mode, DIR_TAB[i].val[PIX_W-1:0], DIR_TAB[i].chk,
                          DIR_TAB[i].want);
            end
        end

        stop_at = n_items + RAND_ITEMS;
        while (n_items < stop_at) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            settle();
            if ($urandom_range(0, 2) != 0) write_width(pick_width());
            if (n_pts > 40 || $urandom_range(0, 3) != 0)
                send_item(MODE_CLEAR, '0, 1'b0, NO_RES);
            nload = $urandom_range(1, 24);
            repeat (nload) send_item(MODE_LOAD, pick_pixel(), 1'b0, NO_RES);
            nreq = n_pts - n_visited + $urandom_range(0, 1);
            repeat (nreq) begin
                r = $urandom_range(0, 99);
                if (r < 6) send_item(MODE_LOAD, pick_pixel(), 1'b0, NO_RES);
                else if (r < 10) send_item(MODE_UNUSED, PIX_W'($urandom), 1'b0, NO_RES);
                else if (r < 11) send_item(MODE_CLEAR, PIX_W'($urandom), 1'b0, NO_RES);
                send_item(MODE_REQ, PIX_W'($urandom), 1'b0, NO_RES);
            end
        end

        settle();
        repeat (64) @(posedge i_clk);
        $display("Sent %0d transactions with %0d width writes, width limits and ties included",
                 n_items, n_width_writes);
        $display("Checked %0d path points and %0d done replies", n_path_pts, n_done);
        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
